>>> src/adaptive_breakpoint_scan_segmenter_top_assert.svh
// Assertion macros for the checker of the segmenter.
`ifndef ADAPTIVE_BREAKPOINT_SCAN_SEGMENTER_TOP_ASSERT_SVH
`define ADAPTIVE_BREAKPOINT_SCAN_SEGMENTER_TOP_ASSERT_SVH

// Clocked property that is switched off while reset is asserted.
`define ABSS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("abss checker: property failed");

// Clocked property that also holds across reset.
`define ABSS_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("abss checker: reset property failed");

`endif

>>> src/abss_pkg.sv
package abss_pkg;

    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned RATIO_W      = 16;
    localparam int unsigned LIMIT_W      = 16;
    localparam int unsigned NEAR_NOISE_W = 10;
    localparam int unsigned MIN_LEN_W    = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_LOW        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_HIGH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_RANGE_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_NOISE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEGMENT_LEN  = 3'd4;

    localparam logic [RATIO_W-1:0]      RST_RATIO_LOW        = 16'd16768;
    localparam logic [RATIO_W-1:0]      RST_RATIO_HIGH       = 16'd16000;
    localparam logic [LIMIT_W-1:0]      RST_NEAR_RANGE_LIMIT = 16'd1000;
    localparam logic [NEAR_NOISE_W-1:0] RST_NEAR_NOISE       = 10'd10;
    localparam logic [MIN_LEN_W-1:0]    RST_MIN_SEGMENT_LEN  = 4'd4;

    // Fraction bits of the band ratios, noise divisor and noise multiple.
    localparam int unsigned Q_SHIFT      = 14;
    localparam int unsigned NOISE_DIV    = 100;
    localparam int unsigned NOISE_SIGMAS = 3;

    typedef struct packed {
        logic [RATIO_W-1:0]      ratio_low;
        logic [RATIO_W-1:0]      ratio_high;
        logic [LIMIT_W-1:0]      near_range_limit;
        logic [NEAR_NOISE_W-1:0] near_noise;
        logic [MIN_LEN_W-1:0]    min_segment_len;
    } t_cfg;

endpackage

>>> src/abss_if.sv
interface abss_sample_if #(
    parameter int RANGE_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [RANGE_BITS-1:0] range_sample;
    logic                  scan_last;

    modport source (output valid, range_sample, scan_last, input ready);
    modport sink   (input valid, range_sample, scan_last, output ready);
endinterface

interface abss_result_if #(
    parameter int RANGE_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [RANGE_BITS-1:0] filtered_range;
    logic                  out_last;

    modport source (output valid, filtered_range, out_last, input ready);
    modport sink   (input valid, filtered_range, out_last, output ready);
endinterface

>>> src/adaptive_breakpoint_scan_segmenter_top.sv
// Adaptive breakpoint scan segmenter.
// Range samples of a scan enter on i_sample (valid/ready), scan_last on the
// final beam. Every sample leaves exactly once on o_result, in order: unchanged
// if its segment grows past min_segment_len or reaches PENDING_DEPTH, else as zero.
// out_last follows the scan_last of the sample it belongs to.
// Samples are held in a circular buffer of 2*PENDING_DEPTH entries. A sample
// whose segment is already known to be long moves on to the output register
// once the items ahead have left; samples of an open short segment wait until
// a break, the end of the scan or promotion to a long segment decides them.
// Throughput is one item per cycle on each side unless stalled. i_sample.ready
// depends only on buffer occupancy, so a stalled receiver keeps input flowing
// until the buffer fills; o_result then holds its item until it is taken.
// The band test against the previous sample (two 16-bit ratio products and a
// compare) and the previous-range/100 term, formed when a sample is taken,
// set the single-cycle path.
// Reset (synchronous, active low) empties the buffer, starts a new scan and
// loads the default configuration. Configuration is written over i_cfg_*, one
// register per cycle, by the user only while the block is idle (not enforced).
module adaptive_breakpoint_scan_segmenter_top #(
    parameter int PENDING_DEPTH = 16,
    parameter int RANGE_BITS    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [abss_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [abss_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    abss_sample_if.sink                      i_sample,
    abss_result_if.source                    o_result
);
    import abss_pkg::*;

    localparam int BUF_DEPTH = 2 * PENDING_DEPTH;
    localparam int PTR_W     = $clog2(BUF_DEPTH);
    localparam int XW        = PTR_W + 1;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int PEND_W    = $clog2(PENDING_DEPTH + 1);
    localparam int LEN_W     = (PEND_W > MIN_LEN_W) ? PEND_W : MIN_LEN_W;
    localparam int NOISE_W   = (RANGE_BITS - 6 > NEAR_NOISE_W) ? RANGE_BITS - 6 : NEAR_NOISE_W;
    localparam int PROD_W    = RANGE_BITS + RATIO_W;
    localparam int MARG_W    = NOISE_W + Q_SHIFT + 2;
    localparam int SUM_W     = ((PROD_W > MARG_W) ? PROD_W : MARG_W) + 1;
    localparam int CMP_W     = (RANGE_BITS > LIMIT_W) ? RANGE_BITS : LIMIT_W;
    // Reciprocal of the noise divisor; the divisor is below 2^7.
    localparam int DIV_S     = RANGE_BITS + 7;
    localparam int DIV_M_W   = RANGE_BITS + 1;
    localparam int DIV_P_W   = 2 * RANGE_BITS + 1;
    localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'((64'd1 << DIV_S) / 64'(NOISE_DIV));

    // Configuration registers.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ratio_low        <= RST_RATIO_LOW;
            r_cfg.ratio_high       <= RST_RATIO_HIGH;
            r_cfg.near_range_limit <= RST_NEAR_RANGE_LIMIT;
            r_cfg.near_noise       <= RST_NEAR_NOISE;
            r_cfg.min_segment_len  <= RST_MIN_SEGMENT_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RATIO_LOW:        r_cfg.ratio_low        <= i_cfg_data[RATIO_W-1:0];
                CFG_RATIO_HIGH:       r_cfg.ratio_high       <= i_cfg_data[RATIO_W-1:0];
                CFG_NEAR_RANGE_LIMIT: r_cfg.near_range_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_NEAR_NOISE:       r_cfg.near_noise       <= i_cfg_data[NEAR_NOISE_W-1:0];
                CFG_MIN_SEGMENT_LEN:  r_cfg.min_segment_len  <= i_cfg_data[MIN_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Segmentation state.
    logic [RANGE_BITS-1:0] r_prev, n_prev;
    logic [NOISE_W-1:0]    r_prev_div, n_prev_div;
    logic                  r_started, n_started;
    logic [PEND_W-1:0]     r_pend, n_pend;
    logic                  r_long, n_long;

    // Buffer state.
    logic [RANGE_BITS:0]   r_mem [BUF_DEPTH];
    logic                  r_zero [BUF_DEPTH];
    logic                  n_zero [BUF_DEPTH];
    logic [PTR_W-1:0]      r_head, n_head;
    logic [PTR_W-1:0]      r_tail, n_tail;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    // Output register.
    logic                  r_ov, n_ov;
    logic [RANGE_BITS:0]   r_od;
    logic                  r_oz;

    logic push, pop;
    logic [RANGE_BITS-1:0] smp;

    assign smp            = i_sample.range_sample;
    assign i_sample.ready = (r_cnt < CNT_W'(BUF_DEPTH));
    assign push           = i_sample.valid && i_sample.ready;
    assign pop            = (r_cnt > CNT_W'(r_pend)) && (!r_ov || o_result.ready);

    assign o_result.valid          = r_ov;
    assign o_result.filtered_range = r_oz ? '0 : r_od[RANGE_BITS-1:0];
    assign o_result.out_last       = r_od[RANGE_BITS];

    // New sample divided by the noise divisor: reciprocal estimate, then one
    // correction step since the estimate is at most one low.
    logic [DIV_P_W-1:0]    div_prod;
    logic [NOISE_W-1:0]    div_q0;
    logic [RANGE_BITS:0]   div_rem;

    assign div_prod   = DIV_P_W'(smp) * DIV_P_W'(DIV_M);
    assign div_q0     = NOISE_W'(div_prod >> DIV_S);
    assign div_rem    = (RANGE_BITS + 1)'(smp)
                      - (RANGE_BITS + 1)'((RANGE_BITS + 1)'(div_q0)
                                          * (RANGE_BITS + 1)'(NOISE_DIV));
    assign n_prev_div = (div_rem >= (RANGE_BITS + 1)'(NOISE_DIV)) ? div_q0 + 1'b1 : div_q0;
    assign n_prev     = smp;

    // Band test of the new sample against the previous one, all scaled by 2^14.
    logic [NOISE_W-1:0] noise;
    logic [PROD_W-1:0]  prod_lo, prod_hi;
    logic [SUM_W-1:0]   margin, scaled;
    logic               in_band;

    assign noise   = (CMP_W'(r_prev) < CMP_W'(r_cfg.near_range_limit))
                   ? NOISE_W'(r_cfg.near_noise) : r_prev_div;
    assign prod_lo = PROD_W'(r_prev) * PROD_W'(r_cfg.ratio_low);
    assign prod_hi = PROD_W'(r_prev) * PROD_W'(r_cfg.ratio_high);
    assign margin  = (SUM_W'(noise) << Q_SHIFT) * SUM_W'(NOISE_SIGMAS);
    assign scaled  = SUM_W'(smp) << Q_SHIFT;
    assign in_band = (scaled + margin > SUM_W'(prod_lo))
                  && (scaled < SUM_W'(prod_hi) + margin);

    // Segment decisions for the item being taken.
    logic              brk, promote, new_zero, region_set, region_val;
    logic [PEND_W-1:0] pend_a, pend_1;
    logic [PTR_W-1:0]  region_start;

    always_comb begin
        brk        = !r_started || !in_band;
        pend_a     = brk ? '0 : r_pend;
        pend_1     = pend_a + 1'b1;
        promote    = (LEN_W'(pend_1) > LEN_W'(r_cfg.min_segment_len))
                  || (pend_1 >= PEND_W'(PENDING_DEPTH));
        n_pend     = r_pend;
        n_long     = r_long;
        n_started  = r_started;
        new_zero   = 1'b1;
        region_set = 1'b0;
        region_val = 1'b1;

        if (push) begin
            n_started = !i_sample.scan_last;
            // A break zeroes the open short segment; otherwise the open
            // segment shares the fate of the new sample.
            if (brk) begin
                region_set = !r_long && (r_pend != '0);
                region_val = 1'b1;
            end else begin
                region_set = promote || i_sample.scan_last;
                region_val = !promote;
            end

            if ((!brk && r_long) || promote) begin
                n_pend   = '0;
                n_long   = !i_sample.scan_last;
                new_zero = 1'b0;
            end else if (i_sample.scan_last) begin
                n_pend   = '0;
                n_long   = 1'b0;
                new_zero = 1'b1;
            end else begin
                n_pend   = pend_1;
                n_long   = 1'b0;
                new_zero = 1'b1;
            end
        end
    end

    // Open segment occupies the r_pend entries just below the tail.
    always_comb begin
        if (XW'(r_tail) >= XW'(r_pend)) begin
            region_start = PTR_W'(XW'(r_tail) - XW'(r_pend));
        end else begin
            region_start = PTR_W'(XW'(r_tail) + XW'(BUF_DEPTH) - XW'(r_pend));
        end
    end

    always_comb begin
        logic [XW-1:0] offs;
        for (int i = 0; i < BUF_DEPTH; i++) begin
            offs = XW'(i) + XW'(BUF_DEPTH) - XW'(region_start);
            if (offs >= XW'(BUF_DEPTH)) begin
                offs = offs - XW'(BUF_DEPTH);
            end
            n_zero[i] = r_zero[i];
            if (region_set && (offs < XW'(r_pend))) begin
                n_zero[i] = region_val;
            end
            if (push && (r_tail == PTR_W'(i))) begin
                n_zero[i] = new_zero;
            end
        end
    end

    always_comb begin
        n_tail = r_tail;
        n_head = r_head;
        if (push) begin
            n_tail = (r_tail == PTR_W'(BUF_DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (pop) begin
            n_head = (r_head == PTR_W'(BUF_DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        n_cnt = CNT_W'(r_cnt + CNT_W'(push) - CNT_W'(pop));
        if (pop) begin
            n_ov = 1'b1;
        end else if (o_result.ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_prev_div <= '0;
            r_started  <= 1'b0;
            r_pend     <= '0;
            r_long     <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_cnt      <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (push) begin
                r_prev     <= n_prev;
                r_prev_div <= n_prev_div;
            end
            r_started <= n_started;
            r_pend    <= n_pend;
            r_long    <= n_long;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_cnt     <= n_cnt;
            r_ov      <= n_ov;
        end
    end

    // Sample memory: written at the tail, read into the output register.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_tail] <= {i_sample.scan_last, smp};
        end
        if (pop) begin
            r_od <= r_mem[r_head];
            r_oz <= r_zero[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < BUF_DEPTH; i++) begin
            r_zero[i] <= n_zero[i];
        end
    end

endmodule

>>> src/abss_checker.sv
`include "adaptive_breakpoint_scan_segmenter_top_assert.svh"

module abss_checker #(
    parameter int PENDING_DEPTH = 16,
    parameter int RANGE_BITS    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [RANGE_BITS-1:0] i_filtered_range,
    input  logic                  i_out_last
);
    localparam int BUF_DEPTH = 2 * PENDING_DEPTH;
    localparam int OUT_W     = $clog2(BUF_DEPTH + 2);

    // Items taken in but not yet delivered.
    logic [OUT_W-1:0] r_outstanding, n_outstanding;

    assign n_outstanding = OUT_W'(r_outstanding + OUT_W'(i_in_valid && i_in_ready)
                                  - OUT_W'(i_out_valid && i_out_ready));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    `ABSS_ASSERT_RST(a_reset_empties, i_clk, !i_rst_n |=> !i_out_valid && i_in_ready)
    `ABSS_ASSERT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_filtered_range) && $stable(i_out_last))
    `ABSS_ASSERT(a_no_invented_item, i_clk, i_rst_n, i_out_valid |-> r_outstanding != '0)
    `ABSS_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, !i_in_ready |-> r_outstanding >= OUT_W'(BUF_DEPTH))

endmodule

bind adaptive_breakpoint_scan_segmenter_top abss_checker #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .RANGE_BITS    (RANGE_BITS)
) u_abss_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_sample.valid),
    .i_in_ready       (i_sample.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_filtered_range (o_result.filtered_range),
    .i_out_last       (o_result.out_last)
);
